FILE: rtl/pscf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch synthesis comb filter package
// Shared widths, constants, types and codes for the comb filter block.
// ----------------------------------------------------------------------------
package pscf_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int GAIN_W        = 16;
    localparam int LAG_W         = 11;
    localparam int FLEN_W        = 11;
    localparam int FPOS_W        = 11;
    localparam int PROD_W        = SAMPLE_W + GAIN_W + 1;
    localparam int FRAC_SHIFT    = 14;
    localparam int RND_W         = PROD_W - FRAC_SHIFT;
    localparam int SUM_W         = RND_W + 1;
    localparam int MAX_FRAME_DEF = 1024;

    localparam logic [FLEN_W-1:0]         FLEN_RESET = 11'd256;
    localparam logic signed [PROD_W-1:0]  ROUND_HALF = 33'sd8192;
    localparam logic signed [SUM_W-1:0]   SUM_MAX    = 20'sd32767;
    localparam logic signed [SUM_W-1:0]   SUM_MIN    = -20'sd32768;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic [LAG_W-1:0]           lag_t;
    typedef logic [FLEN_W-1:0]          flen_t;
    typedef logic [FPOS_W-1:0]          fpos_t;

    typedef enum logic [1:0]
    {
        TAP_NONE = 2'd0,
        TAP_SELF = 2'd1,
        TAP_HIST = 2'd2
    } tap_mode_t;

    typedef struct packed
    {
        sample_t   sample;
        gain_t     gain;
        tap_mode_t mode;
    } req_t;

    typedef struct packed
    {
        logic busy;
        logic advance;
        logic fwd;
        logic hist;
    } mac_stat_t;

endpackage

FILE: rtl/pscf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch synthesis comb filter channels
// Valid/ready channels for input samples, filtered samples and configuration.
// ----------------------------------------------------------------------------
interface pscf_in_if
    import pscf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;
    gain_t   gain;
    lag_t    lag;
    logic    frame_start;
    logic    look_back;

    modport source (output valid, output sample, output gain, output lag,
                    output frame_start, output look_back, input ready);
    modport sink   (input valid, input sample, input gain, input lag,
                    input frame_start, input look_back, output ready);
endinterface

interface pscf_out_if
    import pscf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

interface pscf_cfg_if
    import pscf_pkg::*;
();
    logic  valid;
    logic  ready;
    flen_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pscf_hist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output history memory
// Single-port-read, single-port-write memory with a registered read.
// ----------------------------------------------------------------------------
module pscf_hist_mem
    import pscf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int AW        = $clog2(MAX_FRAME)
)
(
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  sample_t       wdata,
    output sample_t       rdata
);

    sample_t mem [MAX_FRAME];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pscf_frame_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame control
// Tracks frame position, holds gain and lag for the frame and forms the
// history read address for each accepted sample.
// ----------------------------------------------------------------------------
module pscf_frame_ctrl
    import pscf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int AW        = $clog2(MAX_FRAME)
)
(
    input  logic          clk,
    input  logic          rst_n,
    pscf_in_if.sink       samples,
    input  logic          accept,
    pscf_cfg_if.sink      cfg,
    output req_t          req,
    output logic [AW-1:0] raddr,
    output logic [AW-1:0] waddr
);

    localparam int DW = ((AW > LAG_W) ? AW : LAG_W) + 1;

    logic [AW-1:0] wp_reg, wp_next;
    fpos_t         fpos_reg, fpos_next;
    flen_t         flen_reg;
    logic          usable_reg, usable_eff;
    gain_t         gain_reg, gain_eff;
    lag_t          lag_reg, lag_eff;
    fpos_t         fpos_eff;
    logic          start;
    logic [DW-1:0] diff;

    always_comb
    begin
        start      = samples.frame_start || (fpos_reg >= flen_reg);
        gain_eff   = start ? samples.gain : gain_reg;
        lag_eff    = start ? samples.lag : lag_reg;
        usable_eff = start ? samples.look_back : usable_reg;
        fpos_eff   = start ? '0 : fpos_reg;

        req.sample = samples.sample;
        req.gain   = gain_eff;
        if (lag_eff == '0)
        begin
            req.mode = TAP_SELF;
        end
        else if ((int'(lag_eff) <= MAX_FRAME) &&
                 ((fpos_eff >= FPOS_W'(lag_eff)) || usable_eff))
        begin
            req.mode = TAP_HIST;
        end
        else
        begin
            req.mode = TAP_NONE;
        end

        diff = DW'(wp_reg) - DW'(lag_eff);
        if (diff[DW-1])
        begin
            raddr = AW'(diff + DW'(MAX_FRAME));
        end
        else
        begin
            raddr = AW'(diff);
        end

        wp_next   = (wp_reg == AW'(MAX_FRAME - 1)) ? '0 : wp_reg + 1'b1;
        fpos_next = (fpos_eff == '1) ? fpos_eff : fpos_eff + 1'b1;
    end

    assign waddr     = wp_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            fpos_reg   <= '0;
            usable_reg <= 1'b0;
            gain_reg   <= '0;
            lag_reg    <= '0;
            flen_reg   <= FLEN_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                flen_reg <= cfg.data;
            end
            if (accept)
            begin
                wp_reg     <= wp_next;
                fpos_reg   <= fpos_next;
                usable_reg <= usable_eff;
                gain_reg   <= gain_eff;
                lag_reg    <= lag_eff;
            end
        end
    end

endmodule

FILE: rtl/pscf_tap_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tap multiply-accumulate stage
// Selects the feedback tap, multiplies by the gain, rounds, adds the input
// sample, saturates, writes the history memory and holds the result.
// ----------------------------------------------------------------------------
module pscf_tap_mac
    import pscf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF,
    parameter int AW        = $clog2(MAX_FRAME)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  req_t          req,
    input  logic [AW-1:0] raddr,
    input  logic [AW-1:0] waddr,
    input  sample_t       mem_rdata,
    output logic          in_ready,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output sample_t       mem_wdata,
    pscf_out_if.source    results,
    output mac_stat_t     stat
);

    logic                      s1_valid_reg;
    req_t                      s1_req_reg;
    logic [AW-1:0]             s1_waddr_reg;
    logic                      fwd_reg;
    sample_t                   fwd_data_reg;
    logic                      out_valid_reg;
    sample_t                   out_data_reg;

    logic                      s1_adv;
    sample_t                   tap;
    logic signed [PROD_W-1:0]  prod;
    logic signed [RND_W-1:0]   rnd;
    logic signed [SUM_W-1:0]   sum;
    sample_t                   y;

    always_comb
    begin
        s1_adv   = s1_valid_reg && (!out_valid_reg || results.ready);
        in_ready = !s1_valid_reg || s1_adv;

        case (s1_req_reg.mode)
            TAP_SELF: tap = s1_req_reg.sample;
            TAP_HIST: tap = fwd_reg ? fwd_data_reg : mem_rdata;
            default:  tap = '0;
        endcase

        prod = PROD_W'(s1_req_reg.gain) * PROD_W'(tap) + ROUND_HALF;
        rnd  = prod[PROD_W-1:FRAC_SHIFT];
        sum  = SUM_W'(s1_req_reg.sample) + SUM_W'(rnd);
        if (sum > SUM_MAX)
        begin
            y = SUM_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SUM_MIN)
        begin
            y = SUM_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            y = sum[SAMPLE_W-1:0];
        end
    end

    assign mem_we             = s1_adv;
    assign mem_waddr          = s1_waddr_reg;
    assign mem_wdata          = y;
    assign results.valid      = out_valid_reg;
    assign results.out_sample = out_data_reg;
    assign stat.busy          = s1_valid_reg;
    assign stat.advance       = s1_adv;
    assign stat.fwd           = fwd_reg;
    assign stat.hist          = (s1_req_reg.mode == TAP_HIST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_adv && (s1_waddr_reg == raddr) &&
                                (req.mode == TAP_HIST);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req;
            s1_waddr_reg <= waddr;
            fwd_data_reg <= y;
        end
        if (s1_adv)
        begin
            out_data_reg <= y;
        end
    end

endmodule

FILE: rtl/pitch_synthesis_comb_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pitch synthesis comb filter unit
// Long-term synthesis filter y[n] = sat(x[n] + round(g * T)), T = y[n-lag] or
// x[n] for a zero lag, over frames of configurable length, with the output history in a memory.
// ----------------------------------------------------------------------------
// The unit accepts one sample per clock cycle in sustained operation while
// the result channel is ready; a sample passes the tap stage register and
// then the output register, which raises result valid. The rate is set by
// the single read port of the history memory and by the combinational
// multiply, round, add and saturate loop; a lag of one is served by
// forwarding the result that is written in the same cycle as the read.
// The history memory needs no clearing pass after reset. The frame length
// register may be written only while no sample is in flight.
// ----------------------------------------------------------------------------
module pitch_synthesis_comb_filter_unit
    import pscf_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    pscf_in_if.sink    samples,
    pscf_out_if.source results,
    pscf_cfg_if.sink   cfg
);

    localparam int AW = $clog2(MAX_FRAME);

    logic          accept;
    logic          in_ready;
    req_t          req;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    sample_t       mem_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    sample_t       mem_wdata;
    mac_stat_t     stat;

    assign samples.ready = in_ready;
    assign accept        = samples.valid && in_ready;

    pscf_frame_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_frame_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .accept  (accept),
        .cfg     (cfg),
        .req     (req),
        .raddr   (raddr),
        .waddr   (waddr)
    );

    pscf_hist_mem #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_hist_mem (
        .clk   (clk),
        .re    (accept),
        .raddr (raddr),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pscf_tap_mac #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW)
    ) u_tap_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .raddr     (raddr),
        .waddr     (waddr),
        .mem_rdata (mem_rdata),
        .in_ready  (in_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .results   (results),
        .stat      (stat)
    );

    // An accepted transaction always occupies the tap stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> stat.busy)
        else $error("accepted sample did not reach the tap stage");

    // Forwarded history data is used only by a sample that reads the history.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy && stat.fwd |-> stat.hist)
        else $error("forwarding flagged for a sample without a history tap");

    // A stalled sample in the tap stage is held, not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy && !stat.advance |=> stat.busy)
        else $error("stalled sample lost from the tap stage");

    // The history is written exactly when a result enters the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> results.valid)
        else $error("history write without a following result");

endmodule
